/* sv/line_split_request_issuer_unit_assert.svh */
// Assertion macros shared by the line split request issuer RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef LINE_SPLIT_REQUEST_ISSUER_UNIT_ASSERT_SVH
`define LINE_SPLIT_REQUEST_ISSUER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSRI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lsri_pkg.sv */
// Shared types and constants of the line split request issuer.
// No dependencies; used by lsri_rem_unit and the top level.
package lsri_pkg;

  localparam int ADDR_W = 64;
  localparam int LEN_W  = 13;
  localparam int TAG_W  = 6;
  localparam int CNT_W  = 7;
  localparam int MAXP_W = 6;
  localparam int LINE_MAX = 4096;

  localparam logic REG_LINE_SIZE   = 1'b0;
  localparam logic REG_MAX_PENDING = 1'b1;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RESP  = 2'd2,
    OP_EXIT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ISSUED      = 3'd0,
    ST_STALLED     = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_ZERO_LEN    = 3'd3,
    ST_RESP_OK     = 3'd4,
    ST_UNKNOWN_TAG = 3'd5,
    ST_HALTED      = 3'd6,
    ST_EXIT        = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_DEC,
    S_OUT0,
    S_OUT1
  } state_t;

  typedef struct packed {
    status_t             status;
    logic                valid;
    logic                write;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
    logic [TAG_W-1:0]    tag;
    logic [CNT_W-1:0]    outst;
    logic                last;
  } res_t;

endpackage

/* sv/lsri_rem_unit.sv */
// Bit-serial remainder of a 64-bit address by the line size, one bit a cycle.
// Depends on lsri_pkg for the address and length widths.
module lsri_rem_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lsri_pkg::ADDR_W-1:0] dividend,
  input  logic [lsri_pkg::LEN_W-1:0]  divisor,
  output logic                       done,
  output logic [lsri_pkg::LEN_W-1:0]  rem
);
  import lsri_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADDR_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   cnt_r;
  logic [ADDR_W-1:0]   a_r;
  logic [LEN_W-1:0]    rem_r;
  logic [LEN_W-1:0]    trial;

  // The remainder stays below the divisor, which never exceeds 4096, so its
  // top bit is always clear before the shift.
  assign trial = {rem_r[LEN_W-2:0], a_r[ADDR_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      a_r <= {a_r[ADDR_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_r <= trial - divisor;
      end else begin
        rem_r <= trial;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* sv/line_split_request_issuer_unit.sv */
// Channel | Direction | Contents
// in_     | slave     | tuser: operation; tdata: address, length, tag
// out_    | master    | tuser: status, issue_valid; tdata: issue, outstanding; tlast: last
// cfg_    | slave     | cfg_index selects line_size or max_pending, cfg_data is the value
//
// A read or write request that reaches the split check goes from acceptance through
// evaluation, the serial remainder over the 64 address bits, the split decision and one
// or two output beats back to idle, where the next request can be accepted.
// Exit, responses and refused requests go from evaluation straight to the output and wait there.
// Reset (rst_n, synchronous, active low) clears the tag table and counters.
// One request is in flight at a time; a stalled output holds the sequencer.
//
// Top level of the line split request issuer; uses lsri_pkg and lsri_rem_unit,
// and the assertion macros of line_split_request_issuer_unit_assert.svh.
`include "line_split_request_issuer_unit_assert.svh"

module line_split_request_issuer_unit #(
  parameter int TAG_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // address[63:0], length[76:64], tag[82:77], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // issue_write[0], issue_address[64:1],
                                  // issue_length[77:65], issue_tag[83:78],
                                  // outstanding[90:84], zero pad
  output logic [3:0]  out_tuser,  // status[2:0], issue_valid[3]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import lsri_pkg::*;

  localparam int USED_SLOTS = (TAG_SLOTS < 64) ? TAG_SLOTS : 64;
  localparam int IW = $clog2(USED_SLOTS);
  localparam logic [CNT_W-1:0] USED_L = CNT_W'(USED_SLOTS);
  localparam logic [LEN_W-1:0] LINE_MAX_L = LEN_W'(LINE_MAX);

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [LEN_W-1:0]    len_r;
  logic [TAG_W-1:0]    tag_r;
  logic [LEN_W-1:0]    line_r;
  logic [MAXP_W-1:0]   maxp_r;
  logic                halted_r;
  logic [USED_SLOTS-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0]    pending_r;
  logic [CNT_W-1:0]    sc_r;
  logic                found0_r, found1_r;
  logic [TAG_W-1:0]    free0_r, free1_r;
  res_t                res0_r, res1_r;

  logic [LEN_W-1:0]    line_eff;
  logic                tag_hit;
  logic                need_div;
  res_t                quick_res;
  logic [LEN_W-1:0]    rem;
  logic                rem_done;
  logic                rem_start;
  logic [LEN_W:0]      span;
  logic                split;
  logic                can_issue;
  logic [LEN_W-1:0]    left_len;
  logic [ADDR_W-1:0]   right_addr;
  logic                scan_free;
  res_t                dec_res0, dec_res1;
  res_t                cur_res;

  always_comb begin
    if (line_r == '0) begin
      line_eff = LEN_W'(1);
    end else if (line_r > LINE_MAX_L) begin
      line_eff = LINE_MAX_L;
    end else begin
      line_eff = line_r;
    end
  end

  assign tag_hit = ({1'b0, tag_r} < USED_L) && busy_r[tag_r[IW-1:0]];

  // Decide everything that needs no remainder.
  always_comb begin
    quick_res       = '0;
    quick_res.last  = 1'b1;
    quick_res.outst = pending_r;
    need_div        = 1'b0;
    if (halted_r) begin
      quick_res.status = ST_HALTED;
    end else if (op_r == OP_EXIT) begin
      quick_res.status = ST_EXIT;
    end else if (op_r == OP_RESP) begin
      if (tag_hit) begin
        quick_res.status = ST_RESP_OK;
        quick_res.outst  = pending_r - 1'b1;
      end else begin
        quick_res.status = ST_UNKNOWN_TAG;
      end
    end else if (pending_r >= {1'b0, maxp_r}) begin
      quick_res.status = ST_STALLED;
    end else if (len_r > line_eff) begin
      quick_res.status = ST_TOO_LONG;
    end else if (len_r == '0) begin
      quick_res.status = ST_ZERO_LEN;
    end else begin
      need_div = 1'b1;
    end
  end

  assign rem_start = (state_r == S_EVAL) && need_div;

  lsri_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (addr_r),
    .divisor  (line_eff),
    .done     (rem_done),
    .rem      (rem)
  );

  assign span       = {1'b0, rem} + {1'b0, len_r};
  assign split      = span > {1'b0, line_eff};
  assign can_issue  = found0_r && (!split || found1_r);
  assign left_len   = line_eff - rem;
  assign right_addr = addr_r + ADDR_W'(left_len);

  // The slot scan runs alongside the remainder and records the two lowest free tags.
  assign scan_free = (sc_r < USED_L) && !busy_r[sc_r[IW-1:0]];

  // Results of the split decision; without enough free tags the request stalls.
  always_comb begin
    dec_res0        = '0;
    dec_res1        = '0;
    dec_res0.last   = 1'b1;
    dec_res0.outst  = pending_r;
    dec_res0.status = ST_STALLED;
    if (can_issue) begin
      dec_res0.status = ST_ISSUED;
      dec_res0.valid  = 1'b1;
      dec_res0.write  = (op_r == OP_WRITE);
      dec_res0.addr   = addr_r;
      dec_res0.tag    = free0_r;
      dec_res0.outst  = pending_r + 7'd1;
      dec_res0.len    = split ? left_len : len_r;
      dec_res0.last   = !split;
      dec_res1.status = ST_ISSUED;
      dec_res1.valid  = 1'b1;
      dec_res1.write  = (op_r == OP_WRITE);
      dec_res1.addr   = right_addr;
      dec_res1.len    = len_r - left_len;
      dec_res1.tag    = free1_r;
      dec_res1.outst  = pending_r + 7'd2;
      dec_res1.last   = 1'b1;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (state_r == S_EVAL && !halted_r && op_r == OP_RESP && tag_hit) begin
      busy_nxt[tag_r[IW-1:0]] = 1'b0;
    end
    if (state_r == S_DEC && can_issue) begin
      busy_nxt[free0_r[IW-1:0]] = 1'b1;
      if (split) begin
        busy_nxt[free1_r[IW-1:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = need_div ? S_DIV : S_OUT0;
      S_DIV:  if (rem_done) state_nxt = S_DEC;
      S_DEC:  state_nxt = S_OUT0;
      S_OUT0: if (out_tready) state_nxt = res0_r.last ? S_IDLE : S_OUT1;
      S_OUT1: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      line_r    <= LEN_W'(64);
      maxp_r    <= MAXP_W'(16);
      halted_r  <= 1'b0;
      busy_r    <= '0;
      pending_r <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LINE_SIZE) begin
          line_r <= cfg_data;
        end else begin
          maxp_r <= cfg_data[MAXP_W-1:0];
        end
      end
      if (state_r == S_EVAL && !halted_r) begin
        if (op_r == OP_EXIT) begin
          halted_r <= 1'b1;
        end else if (op_r == OP_RESP && tag_hit) begin
          pending_r <= pending_r - 1'b1;
        end
      end
      if (state_r == S_DEC && can_issue) begin
        if (split) begin
          pending_r <= pending_r + 7'd2;
        end else begin
          pending_r <= pending_r + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      op_r   <= op_t'(in_tuser);
      addr_r <= in_tdata[63:0];
      len_r  <= in_tdata[76:64];
      tag_r  <= in_tdata[82:77];
    end
    if (state_r == S_EVAL) begin
      sc_r     <= '0;
      found0_r <= 1'b0;
      found1_r <= 1'b0;
      res0_r   <= quick_res;
    end else if (state_r == S_DIV && sc_r < USED_L) begin
      sc_r <= sc_r + 1'b1;
      if (scan_free) begin
        if (!found0_r) begin
          found0_r <= 1'b1;
          free0_r  <= sc_r[TAG_W-1:0];
        end else if (!found1_r) begin
          found1_r <= 1'b1;
          free1_r  <= sc_r[TAG_W-1:0];
        end
      end
    end else if (state_r == S_DEC) begin
      res0_r <= dec_res0;
      res1_r <= dec_res1;
    end
  end

  assign cur_res    = (state_r == S_OUT1) ? res1_r : res0_r;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT0) || (state_r == S_OUT1);
  assign out_tdata  = {5'b0, cur_res.outst, cur_res.tag, cur_res.len, cur_res.addr,
                       cur_res.write};
  assign out_tuser  = {cur_res.valid, cur_res.status};
  assign out_tlast  = cur_res.last;
  assign cfg_ready  = 1'b1;

  `LSRI_ASSERT_IMPL(a_one_in_flight, out_tvalid, !in_tready, "input taken while a result waits")
  `LSRI_ASSERT_IMPL(a_count_match, 1'b1, $countones(busy_r) == pending_r,
                    "outstanding count differs from busy tag slots")
  `LSRI_ASSERT_IMPL(a_issued_tag_busy, out_tvalid && cur_res.valid,
                    busy_r[cur_res.tag[IW-1:0]], "issued tag is not marked busy")
  `LSRI_ASSERT_NEXT(a_rem_to_dec, rem_done, state_r == S_DEC,
                    "remainder finished outside the split check")

endmodule
